>>> rtl/rgb565_alpha_blend_defines.svh
// ----------------------------------------------------------------------------
// rgb565_alpha_blend_defines : assertion macros
// macros for the file that carries concurrent checks
// ----------------------------------------------------------------------------
`ifndef RGB565_ALPHA_BLEND_DEFINES_SVH
`define RGB565_ALPHA_BLEND_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check that is masked while reset is asserted
`define RAB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// check that also holds across reset
`define RAB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RAB_ASSERT(lbl, clk, rstn, prop, msg)
`define RAB_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/rgbab_pkg.sv
// ----------------------------------------------------------------------------
// rgbab_pkg : rgb565 alpha blend package
// register indexes, bus widths, blend mode values, alpha and channel limits and pixel class codes
// ----------------------------------------------------------------------------
package rgbab_pkg;

    // register map
    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_ENABLE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BLEND_MODE   = 1'b1;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // blend mode values
    localparam logic BLEND_NORMAL   = 1'b0;
    localparam logic BLEND_ADDITIVE = 1'b1;

    // alpha limits
    localparam logic [7:0] ALPHA_ZERO   = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // channel saturation limits
    localparam logic [4:0] CH5_MAX = 5'h1f;
    localparam logic [5:0] CH6_MAX = 6'h3f;

    // how a pixel is resolved
    typedef enum logic [2:0] {
        KIND_DIRECT = 3'b001,   // colour known at decode (pass, opaque, transparent)
        KIND_MIX    = 3'b010,   // normal alpha mix
        KIND_ADD    = 3'b100    // additive with saturation
    } blend_kind_t;

endpackage

>>> rtl/rgb565_alpha_blend.sv
// ----------------------------------------------------------------------------
// rgb565_alpha_blend : texture pixel over rgb565 background blender
// path: an accepted transaction is registered in s1, s2 and then s3, whose
//   registers drive m_valid and the result
// throughput: one pixel per cycle unless m_ready stalls the pipe; three register
//   stages with a multiplier stage in the middle setting the per-cycle depth
// reset: synchronous active-low aresetn clears all stage valids and both
//   configuration registers (alpha off, normal mode)
// ----------------------------------------------------------------------------
`include "rgb565_alpha_blend_defines.svh"

module rgb565_alpha_blend (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rgbab_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rgbab_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rgbab_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    // source pixel channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [31:0]                          s_src_color,
    input  logic [15:0]                          s_bg_color,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [15:0]                          m_out_color,
    output logic                                 m_write_enable
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                                 alpha_enable_reg;
    logic                                 blend_mode_reg;
    logic                                 cfg_write;
    logic [rgbab_pkg::REG_IDX_W-1:0]      cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // registers sit on 4-byte boundaries
    assign cfg_index = paddr[2 +: rgbab_pkg::REG_IDX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_enable_reg <= 1'b0;
            blend_mode_reg   <= rgbab_pkg::BLEND_NORMAL;
        end else if (cfg_write) begin
            case (cfg_index)
                rgbab_pkg::REG_ALPHA_ENABLE: alpha_enable_reg <= pwdata[0];
                rgbab_pkg::REG_BLEND_MODE:   blend_mode_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back, upper bits read as zero
    always_comb begin
        prdata = '0;
        case (cfg_index)
            rgbab_pkg::REG_ALPHA_ENABLE: prdata[0] = alpha_enable_reg;
            rgbab_pkg::REG_BLEND_MODE:   prdata[0] = blend_mode_reg;
            default:                     prdata    = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // each stage takes new data when it is empty or the next one moves;
    // a stall holds each occupied stage back to the first empty one, bubbles are squeezed out
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready = !s3_valid_reg || m_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= s_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: unpack the transaction and classify the pixel
    // ------------------------------------------------------------------
    logic [7:0]              in_alpha;
    logic [15:0]             direct_color_next;
    rgbab_pkg::blend_kind_t  kind_next;

    assign in_alpha = s_src_color[7:0];

    always_comb begin
        direct_color_next = '0;
        kind_next         = rgbab_pkg::KIND_DIRECT;
        if (!alpha_enable_reg) begin
            // no alpha: low half of the source word goes straight out
            direct_color_next = s_src_color[15:0];
        end else if (in_alpha == rgbab_pkg::ALPHA_ZERO) begin
            // fully transparent, colour forced to zero
            direct_color_next = '0;
        end else if (in_alpha == rgbab_pkg::ALPHA_OPAQUE) begin
            // fully opaque, repack source channels
            direct_color_next = {s_src_color[31:27], s_src_color[23:18], s_src_color[15:11]};
        end else if (blend_mode_reg == rgbab_pkg::BLEND_ADDITIVE) begin
            kind_next = rgbab_pkg::KIND_ADD;
        end else begin
            kind_next = rgbab_pkg::KIND_MIX;
        end
    end

    rgbab_pkg::blend_kind_t  s1_kind_reg;
    logic [15:0]             s1_direct_reg;
    logic                    s1_we_reg;
    logic [4:0]              s1_src_r_reg, s1_src_b_reg, s1_bg_r_reg, s1_bg_b_reg;
    logic [5:0]              s1_src_g_reg, s1_bg_g_reg;
    logic [7:0]              s1_alpha_reg;

    // payload only, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s1_ready) begin
            s1_kind_reg   <= kind_next;
            s1_direct_reg <= direct_color_next;
            s1_we_reg     <= !alpha_enable_reg || (in_alpha != rgbab_pkg::ALPHA_ZERO);
            s1_src_r_reg  <= s_src_color[31:27];
            s1_src_g_reg  <= s_src_color[23:18];
            s1_src_b_reg  <= s_src_color[15:11];
            s1_alpha_reg  <= in_alpha;
            s1_bg_r_reg   <= s_bg_color[15:11];
            s1_bg_g_reg   <= s_bg_color[10:5];
            s1_bg_b_reg   <= s_bg_color[4:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: per-channel products, src*a and bg*(255-a)
    // ------------------------------------------------------------------
    logic [7:0]  inv_alpha;
    logic [12:0] ps_r_next, ps_b_next, pb_r_next, pb_b_next;
    logic [13:0] ps_g_next, pb_g_next;

    assign inv_alpha = rgbab_pkg::ALPHA_OPAQUE - s1_alpha_reg;
    assign ps_r_next = 13'(s1_src_r_reg) * 13'(s1_alpha_reg);
    assign ps_g_next = 14'(s1_src_g_reg) * 14'(s1_alpha_reg);
    assign ps_b_next = 13'(s1_src_b_reg) * 13'(s1_alpha_reg);
    assign pb_r_next = 13'(s1_bg_r_reg) * 13'(inv_alpha);
    assign pb_g_next = 14'(s1_bg_g_reg) * 14'(inv_alpha);
    assign pb_b_next = 13'(s1_bg_b_reg) * 13'(inv_alpha);

    rgbab_pkg::blend_kind_t  s2_kind_reg;
    logic [15:0]             s2_direct_reg;
    logic                    s2_we_reg;
    logic [12:0]             s2_ps_r_reg, s2_ps_b_reg, s2_pb_r_reg, s2_pb_b_reg;
    logic [13:0]             s2_ps_g_reg, s2_pb_g_reg;
    logic [4:0]              s2_bg_r_reg, s2_bg_b_reg;
    logic [5:0]              s2_bg_g_reg;

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s2_ready) begin
            s2_kind_reg   <= s1_kind_reg;
            s2_direct_reg <= s1_direct_reg;
            s2_we_reg     <= s1_we_reg;
            s2_ps_r_reg   <= ps_r_next;
            s2_ps_g_reg   <= ps_g_next;
            s2_ps_b_reg   <= ps_b_next;
            s2_pb_r_reg   <= pb_r_next;
            s2_pb_g_reg   <= pb_g_next;
            s2_pb_b_reg   <= pb_b_next;
            s2_bg_r_reg   <= s1_bg_r_reg;
            s2_bg_g_reg   <= s1_bg_g_reg;
            s2_bg_b_reg   <= s1_bg_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: sum and shift for the mix, add and clamp for additive
    // ------------------------------------------------------------------
    logic [13:0] mix_r_sum, mix_b_sum;
    logic [14:0] mix_g_sum;
    logic [15:0] mix_color;
    logic [5:0]  add_r_sum, add_b_sum;
    logic [6:0]  add_g_sum;
    logic [4:0]  add_r, add_b;
    logic [5:0]  add_g;
    logic [15:0] add_color;
    logic [15:0] color_next;

    // the mix never exceeds the channel maximum, so the top bits are zero
    assign mix_r_sum = 14'(s2_ps_r_reg) + 14'(s2_pb_r_reg);
    assign mix_g_sum = 15'(s2_ps_g_reg) + 15'(s2_pb_g_reg);
    assign mix_b_sum = 14'(s2_ps_b_reg) + 14'(s2_pb_b_reg);
    assign mix_color = {mix_r_sum[12:8], mix_g_sum[13:8], mix_b_sum[12:8]};

    // additive: carry out of the channel width means saturate
    assign add_r_sum = 6'(s2_bg_r_reg) + 6'(s2_ps_r_reg[12:8]);
    assign add_g_sum = 7'(s2_bg_g_reg) + 7'(s2_ps_g_reg[13:8]);
    assign add_b_sum = 6'(s2_bg_b_reg) + 6'(s2_ps_b_reg[12:8]);
    assign add_r     = add_r_sum[5] ? rgbab_pkg::CH5_MAX : add_r_sum[4:0];
    assign add_g     = add_g_sum[6] ? rgbab_pkg::CH6_MAX : add_g_sum[5:0];
    assign add_b     = add_b_sum[5] ? rgbab_pkg::CH5_MAX : add_b_sum[4:0];
    assign add_color = {add_r, add_g, add_b};

    always_comb begin
        case (s2_kind_reg)
            rgbab_pkg::KIND_MIX:    color_next = mix_color;
            rgbab_pkg::KIND_ADD:    color_next = add_color;
            rgbab_pkg::KIND_DIRECT: color_next = s2_direct_reg;
            default:                color_next = s2_direct_reg;
        endcase
    end

    // output register parts the result side from the pipeline
    logic [15:0] s3_color_reg;
    logic        s3_we_reg;

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s3_ready) begin
            s3_color_reg <= color_next;
            s3_we_reg    <= s2_we_reg;
        end
    end

    assign m_valid        = s3_valid_reg;
    assign m_out_color    = s3_color_reg;
    assign m_write_enable = s3_we_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `RAB_ASSERT_ALWAYS(a_reset_empties_pipe, aclk,
        !aresetn |=> !s1_valid_reg && !s2_valid_reg && !s3_valid_reg,
        "pipeline not empty after reset")

    `RAB_ASSERT(a_accept_fills_stage1, aclk, aresetn,
        s_valid && s_ready |=> s1_valid_reg,
        "accepted transaction lost at stage 1")

    `RAB_ASSERT(a_stalled_stage2_holds, aclk, aresetn,
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(s2_direct_reg),
        "stage 2 dropped or changed while stalled")

    `RAB_ASSERT(a_transparent_is_zero, aclk, aresetn,
        m_valid && !m_write_enable |-> m_out_color == 16'h0000,
        "suppressed write carries non-zero colour")

endmodule
